@@ rtl/gwwb_pkg.sv @@
// Shared types and constants for the gray-world white balance block.
package gwwb_pkg;

  // Default frame capacity in pixels
  localparam int unsigned DEF_MAX_PIXELS = 16384;

  // Field widths fixed by the interface
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned READ_IDX_W  = 14;
  localparam int unsigned NUM_CHAN    = 3;
  localparam int unsigned PIXEL_W     = NUM_CHAN * SAMPLE_W;

  // Gains are unsigned Q1.16, never above 1.0
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned GAIN_W      = FRAC_BITS + 1;

  // Divider runs one quotient bit per cycle
  localparam int unsigned DIV_STEPS   = GAIN_W;
  localparam int unsigned STEP_W      = $clog2(DIV_STEPS);
  localparam int unsigned CHAN_W      = $clog2(NUM_CHAN);

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Channel selects
  localparam logic [CHAN_W-1:0] CH_FIRST = CHAN_W'(0);
  localparam logic [CHAN_W-1:0] CH_LAST  = CHAN_W'(NUM_CHAN - 1);

  // Input word
  typedef struct packed {
    logic                  command;
    logic [SAMPLE_W-1:0]   chan0_in;
    logic [SAMPLE_W-1:0]   chan1_in;
    logic [SAMPLE_W-1:0]   chan2_in;
    logic [READ_IDX_W-1:0] read_index;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [SAMPLE_W-1:0] chan0_out;
    logic [SAMPLE_W-1:0] chan1_out;
    logic [SAMPLE_W-1:0] chan2_out;
    logic                index_error;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;       // store pixel and add into sums
    logic              capture;    // latch read index and range flag
    logic              div_init;   // load divider for selected channel
    logic              div_step;   // one quotient bit
    logic              div_first;  // integer bit step (no shift)
    logic              gain_wr;    // write finished quotient as gain
    logic              set_phase;  // enter reading phase
    logic              mem_rd;     // read frame store at latched index
    logic              out_load;   // load scaled pixel into output register
    logic [CHAN_W-1:0] chan;       // channel under division
  } gwwb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic reading;   // gains valid for current frame
    logic out_free;  // output register can take a word this cycle
  } gwwb_stat_t;

endpackage

@@ rtl/gwwb_ctrl.sv @@
// Sequencing controller: accepts words, steps the gain divider, drives reads.
module gwwb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_stall,
  input  gwwb_pkg::gwwb_stat_t stat,
  output gwwb_pkg::gwwb_cmd_t  cmd
);
  import gwwb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DINIT = 5'b00010,
    S_DSTEP = 5'b00100,
    S_READ  = 5'b01000,
    S_SCALE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CHAN_W-1:0]   chan_r, chan_nxt;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    chan_nxt  = chan_r;
    cmd       = '0;
    cmd.chan  = chan_r;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_command == CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            if (stat.reading) begin
              state_nxt = S_READ;
            end else begin
              chan_nxt  = CH_FIRST;
              state_nxt = S_DINIT;
            end
          end
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (step_r == '0);
        step_nxt      = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          cmd.gain_wr = 1'b1;
          if (chan_r == CH_LAST) begin
            cmd.set_phase = 1'b1;
            state_nxt     = S_READ;
          end else begin
            chan_nxt  = chan_r + CHAN_W'(1);
            state_nxt = S_DINIT;
          end
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_SCALE;
      end
      S_SCALE: begin
        // hold until the output register frees up
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      chan_r  <= CH_FIRST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      chan_r  <= chan_nxt;
    end
  end

endmodule

@@ rtl/gwwb_dp.sv @@
// Datapath: frame store, channel sums, shared gain divider, scaling and output register.
module gwwb_dp #(
  parameter int unsigned MAX_PIXELS = gwwb_pkg::DEF_MAX_PIXELS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gwwb_pkg::in_word_t   in_data,
  input  gwwb_pkg::gwwb_cmd_t  cmd,
  output gwwb_pkg::gwwb_stat_t stat,
  input  logic                 out_stall,
  output logic                 out_valid,
  output gwwb_pkg::out_word_t  out_data
);
  import gwwb_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned SUM_W  = $clog2(255 * MAX_PIXELS + 1);
  localparam int unsigned CMP_W  = (CNT_W > READ_IDX_W) ? CNT_W : READ_IDX_W;
  localparam int unsigned AEXT_W = (ADDR_W > READ_IDX_W) ? ADDR_W : READ_IDX_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PIXELS);

  // Frame store
  logic [PIXEL_W-1:0] mem [MAX_PIXELS];
  logic [PIXEL_W-1:0] rd_data_r;

  // Frame accumulation state
  logic [SUM_W-1:0]  sum0_r, sum1_r, sum2_r, sum0_nxt, sum1_nxt, sum2_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              reading_r, reading_nxt;

  // Read request
  logic [ADDR_W-1:0] idx_r;
  logic              err_r;

  // Divider and gains
  logic [SUM_W-1:0]  own_r, rem_r, rem_nxt;
  logic [GAIN_W-1:0] quo_r, quo_nxt;
  logic [GAIN_W-1:0] gain0_r, gain1_r, gain2_r;

  // Output register
  logic              out_valid_r;
  out_word_t         out_data_r;

  // Load path
  logic [SUM_W-1:0]  base0, base1, base2;
  logic [CNT_W-1:0]  count_base;
  logic              store_en;

  always_comb begin
    base0      = reading_r ? '0 : sum0_r;
    base1      = reading_r ? '0 : sum1_r;
    base2      = reading_r ? '0 : sum2_r;
    count_base = reading_r ? '0 : count_r;
    store_en   = cmd.load && (count_base != FULL_CNT);
    sum0_nxt   = sum0_r;
    sum1_nxt   = sum1_r;
    sum2_nxt   = sum2_r;
    count_nxt  = count_r;
    reading_nxt = reading_r;
    if (cmd.load) begin
      // a load after reads starts a new frame
      reading_nxt = 1'b0;
      sum0_nxt    = base0;
      sum1_nxt    = base1;
      sum2_nxt    = base2;
      count_nxt   = count_base;
      if (store_en) begin
        sum0_nxt  = base0 + SUM_W'(in_data.chan0_in);
        sum1_nxt  = base1 + SUM_W'(in_data.chan1_in);
        sum2_nxt  = base2 + SUM_W'(in_data.chan2_in);
        count_nxt = count_base + CNT_W'(1);
      end
    end else if (cmd.set_phase) begin
      reading_nxt = 1'b1;
    end
  end

  // Smallest nonzero sum and divisor select
  logic [SUM_W-1:0] smallest, own_sel;

  always_comb begin
    smallest = sum0_r;
    if (sum1_r != '0 && (smallest == '0 || sum1_r < smallest)) smallest = sum1_r;
    if (sum2_r != '0 && (smallest == '0 || sum2_r < smallest)) smallest = sum2_r;
    case (cmd.chan)
      2'd0:    own_sel = sum0_r;
      2'd1:    own_sel = sum1_r;
      default: own_sel = sum2_r;
    endcase
  end

  // One restoring-division step: first step takes the integer bit
  logic [SUM_W:0] trial;
  logic           ge;

  always_comb begin
    trial   = cmd.div_first ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge      = (trial >= {1'b0, own_r});
    rem_nxt = ge ? SUM_W'(trial - {1'b0, own_r}) : SUM_W'(trial);
    quo_nxt = {quo_r[GAIN_W-2:0], ge};
  end

  // Index range check and address
  logic [AEXT_W-1:0] idx_ext;
  logic              idx_bad;

  assign idx_ext = AEXT_W'(in_data.read_index);
  assign idx_bad = (CMP_W'(in_data.read_index) >= CMP_W'(count_r));

  // Scale one sample by its gain, truncated, clamped to 8 bits
  function automatic logic [SAMPLE_W-1:0] scale(input logic [SAMPLE_W-1:0] s,
                                                input logic [GAIN_W-1:0]   g);
    logic [SAMPLE_W+GAIN_W-1:0] prod;
    logic [SAMPLE_W+GAIN_W-FRAC_BITS-1:0] v;
    prod = SAMPLE_W'(s) * g;
    v    = prod[SAMPLE_W+GAIN_W-1:FRAC_BITS];
    if (v > (SAMPLE_W+GAIN_W-FRAC_BITS)'(255)) begin
      scale = 8'hFF;
    end else begin
      scale = v[SAMPLE_W-1:0];
    end
  endfunction

  out_word_t scaled;

  always_comb begin
    if (err_r) begin
      scaled             = '0;
      scaled.index_error = 1'b1;
    end else begin
      scaled.chan0_out   = scale(rd_data_r[SAMPLE_W-1:0], gain0_r);
      scaled.chan1_out   = scale(rd_data_r[2*SAMPLE_W-1:SAMPLE_W], gain1_r);
      scaled.chan2_out   = scale(rd_data_r[3*SAMPLE_W-1:2*SAMPLE_W], gain2_r);
      scaled.index_error = 1'b0;
    end
  end

  // Frame store write and registered read
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[count_base[ADDR_W-1:0]] <= {in_data.chan2_in, in_data.chan1_in, in_data.chan0_in};
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[idx_r];
    end
  end

  // Control and accumulation registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum0_r      <= '0;
      sum1_r      <= '0;
      sum2_r      <= '0;
      count_r     <= '0;
      reading_r   <= 1'b0;
      gain0_r     <= '0;
      gain1_r     <= '0;
      gain2_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum0_r    <= sum0_nxt;
      sum1_r    <= sum1_nxt;
      sum2_r    <= sum2_nxt;
      count_r   <= count_nxt;
      reading_r <= reading_nxt;
      // write gain, zero for a zero-sum channel
      if (cmd.gain_wr) begin
        case (cmd.chan)
          2'd0:    gain0_r <= (own_r == '0) ? '0 : quo_nxt;
          2'd1:    gain1_r <= (own_r == '0) ? '0 : quo_nxt;
          default: gain2_r <= (own_r == '0) ? '0 : quo_nxt;
        endcase
      end
      // output word valid until taken
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= idx_ext[ADDR_W-1:0];
      err_r <= idx_bad;
    end
    if (cmd.div_init) begin
      own_r <= own_sel;
      rem_r <= smallest;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.out_load) begin
      out_data_r <= scaled;
    end
  end

  assign stat.reading  = reading_r;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

@@ rtl/gray_world_white_balance.sv @@
// Gray-world white balance top level: controller plus datapath.
//
//   Channel  Direction  Handshake          Word
//   in_      input      in_valid/in_stall  gwwb_pkg::in_word_t (load or read command)
//   out_     output     out_valid/out_stall gwwb_pkg::out_word_t (one per read)
//
// Loads stream back to back.
// A read passes through accept, frame store read, and scale into the output register.
// The first read of a frame first runs the shared divider once per channel: an init step, then the quotient-bit steps.
// Reset is synchronous, active low; the frame store itself is not cleared.
// A stalled output word holds; the next input word is taken while it waits.
module gray_world_white_balance #(
  parameter int unsigned MAX_PIXELS = gwwb_pkg::DEF_MAX_PIXELS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gwwb_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gwwb_pkg::out_word_t out_data
);
  import gwwb_pkg::*;

  gwwb_cmd_t  cmd;
  gwwb_stat_t stat;

  gwwb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  gwwb_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
